@@ hw/rtl/gmr_pkg.sv @@
// Package for grouped_min_reduce: shared widths, codes, cell state type and
// the binary64 helper functions. Depends on nothing.
package gmr_pkg;

    localparam int          DEF_MAX_GROUPS = 64;
    localparam int          CFG_W          = 7;
    localparam logic [63:0] NA_BITS        = 64'h7FF0_0000_0000_07A2;
    localparam logic [63:0] INF_BITS       = 64'h7FF0_0000_0000_0000;

    typedef enum logic [0:0] {
        REG_NA_REMOVE   = 1'b0,
        REG_GROUP_COUNT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [63:0] min_bits;
        logic        seen;
        logic        has_nan;
    } t_cell;

    function automatic logic is_nan(input logic [63:0] b);
        return (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
    endfunction

    // a > b for two non-NaN binary64 values; +0 and -0 compare equal.
    function automatic logic fp_gt(input logic [63:0] a, input logic [63:0] b);
        logic res;
        if ((a[62:0] == 63'd0) && (b[62:0] == 63'd0)) begin
            res = 1'b0;
        end else if (a[63] != b[63]) begin
            res = !a[63];
        end else if (!a[63]) begin
            res = a[62:0] > b[62:0];
        end else begin
            res = a[62:0] < b[62:0];
        end
        return res;
    endfunction

endpackage

@@ hw/rtl/gmr_cell.sv @@
// One group cell of the minimum chain: holds a group's running minimum and
// flags, updates on a sample hit and shifts toward the head during a dump.
// Depends on gmr_pkg.
module gmr_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_reload,
    input  gmr_pkg::t_cell i_reload_val,
    input  logic          i_shift,
    input  gmr_pkg::t_cell i_next,
    input  logic          i_hit,
    input  logic [63:0]   i_x,
    input  logic          i_na_remove,
    output gmr_pkg::t_cell o_state
);
    import gmr_pkg::*;

    t_cell r_state;
    t_cell n_state;
    logic  x_nan;

    assign x_nan = is_nan(i_x);

    always_comb begin
        n_state = r_state;
        priority if (i_reload) begin
            n_state = i_reload_val;
        end else if (i_shift) begin
            n_state = i_next;
        end else if (i_hit) begin
            if (i_na_remove) begin
                if (x_nan) begin
                    n_state.has_nan = 1'b1;
                end else if (!r_state.seen || fp_gt(r_state.min_bits, i_x)) begin
                    n_state.min_bits = i_x;
                    n_state.seen     = 1'b1;
                end
            end else if (!r_state.has_nan) begin
                if (x_nan) begin
                    n_state.min_bits = i_x;
                    n_state.has_nan  = 1'b1;
                end else begin
                    n_state.seen = 1'b1;
                    if (fp_gt(r_state.min_bits, i_x)) begin
                        n_state.min_bits = i_x;
                    end
                end
            end
        end else begin
            // Nothing happens to this group; the cell holds its state.
            n_state = r_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{min_bits: NA_BITS, seen: 1'b0, has_nan: 1'b0};
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

@@ hw/rtl/grouped_min_reduce.sv @@
// grouped_min_reduce: per-group minimum of a binary64 column, top level.
// A sample is absorbed into its cell when accepted; the first result of a
// column is valid in the cycle after its end-of-column item is accepted.
// Throughput: one sample per cycle while no dump runs; a dump shifts the cell
// chain one group per cycle while the receiver is ready, and blocks samples.
// Reset (synchronous, active low) sets na_remove=1, group_count=0, reloads all cells.
module grouped_min_reduce #(
    parameter int MAX_GROUPS = gmr_pkg::DEF_MAX_GROUPS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write port.
    input  logic                   i_cfg_we,
    input  gmr_pkg::t_reg_idx      i_cfg_idx,
    input  logic [gmr_pkg::CFG_W-1:0] i_cfg_wdata,
    // Sample input stream.
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [71:0]            i_s_tdata,   // [63:0] sample_bits, [70:64] group_number, [71] zero
    input  logic                   i_s_tlast,   // end_of_column
    // Result output stream.
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [71:0]            o_m_tdata,   // [6:0] result_group, [70:7] minimum_bits, [71] zero
    output logic                   o_m_tlast    // last_result
);
    import gmr_pkg::*;

    localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } t_state;

    t_state      r_state, n_state;
    logic        r_na_remove;
    logic [6:0]  r_group_count;
    logic [63:0] r_first_nan;
    logic [GW-1:0] r_idx, n_idx;
    logic [GW-1:0] r_last_idx;
    logic [GW-1:0] last_idx;

    logic        s_acc, m_acc;
    logic [63:0] x;
    logic [6:0]  g;
    logic        reload_all;
    logic        shift;
    logic        na_next;
    t_cell       reload_val;
    t_cell       cells [MAX_GROUPS+1];
    logic [63:0] head_bits;

    assign x     = i_s_tdata[63:0];
    assign g     = i_s_tdata[70:64];
    assign s_acc = i_s_tvalid && o_s_tready;
    assign m_acc = o_m_tvalid && i_m_tready;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = (r_state == S_DUMP);

    // A configuration write restarts the column with the new mode's fill value.
    assign reload_all = i_cfg_we;
    assign na_next    = (i_cfg_we && i_cfg_idx == REG_NA_REMOVE) ? i_cfg_wdata[0]
                                                                 : r_na_remove;
    assign reload_val = '{min_bits: (na_next ? NA_BITS : INF_BITS),
                          seen: 1'b0, has_nan: 1'b0};
    assign shift      = m_acc;
    assign cells[MAX_GROUPS] = reload_val;

    // Index of the last group in use, with an oversized count clamped.
    always_comb begin
        if (r_group_count == 7'd0) begin
            last_idx = '0;
        end else if (32'(r_group_count) > MAX_GROUPS) begin
            last_idx = GW'(MAX_GROUPS - 1);
        end else begin
            last_idx = GW'(r_group_count - 7'd1);
        end
    end

    for (genvar i = 0; i < MAX_GROUPS; i++) begin : g_cell
        logic hit;
        assign hit = s_acc && ((r_group_count == 7'd0) ? (i == 0)
                     : ((32'(g) == i + 1) && (g <= r_group_count)));
        gmr_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_reload     (reload_all),
            .i_reload_val (reload_val),
            .i_shift      (shift),
            .i_next       (cells[i+1]),
            .i_hit        (hit),
            .i_x          (x),
            .i_na_remove  (r_na_remove),
            .o_state      (cells[i])
        );
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (s_acc && i_s_tlast) begin
                    n_state = S_DUMP;
                end
            end
            S_DUMP: begin
                if (m_acc) begin
                    n_idx = r_idx + GW'(1);
                    if (r_idx == r_last_idx) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_idx         <= '0;
            r_last_idx    <= '0;
            r_na_remove   <= 1'b1;
            r_group_count <= 7'd0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (s_acc && i_s_tlast) begin
                r_last_idx <= last_idx;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_NA_REMOVE:   r_na_remove   <= i_cfg_wdata[0];
                    REG_GROUP_COUNT: r_group_count <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // First NaN of an ungrouped column, used when no number was seen.
    always_ff @(posedge i_clk) begin
        if (s_acc && r_group_count == 7'd0 && r_na_remove && is_nan(x)
            && !cells[0].has_nan) begin
            r_first_nan <= x;
        end
    end

    assign head_bits = (r_na_remove && r_group_count == 7'd0 && !cells[0].seen)
                       ? r_first_nan : cells[0].min_bits;

    assign o_m_tdata = {1'b0, head_bits, 7'(r_idx) + 7'd1};
    assign o_m_tlast = (r_idx == r_last_idx);

    a_dump_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(i_s_tvalid && o_s_tready && i_s_tlast))
        else $error("dump started without end-of-column item");
    a_no_take_in_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready)
        else $error("sample accepted during dump");
    a_last_ends_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast) |=> !o_m_tvalid)
        else $error("dump continued after last result");

endmodule

@@ tb/gmr_checker.sv @@
// Checker for grouped_min_reduce: watches the configuration port and both
// streams, predicts the per-group minima and compares every result item.
// Depends on gmr_pkg for the register index type and the NA/+Inf patterns.
module gmr_checker #(
    parameter int MAX_GROUPS = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  gmr_pkg::t_reg_idx      i_cfg_idx,
    input  logic [gmr_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [71:0]            i_s_tdata,   // [63:0] sample_bits, [70:64] group_number, [71] zero
    input  logic                   i_s_tlast,   // end_of_column
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [71:0]            i_m_tdata,   // [6:0] result_group, [70:7] minimum_bits, [71] zero
    input  logic                   i_m_tlast,   // last_result
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct {
        logic [6:0]  grp;
        logic [63:0] min_bits;
        logic        last;
    } t_group_result;

    t_group_result expected_minima[$];

    logic        drop_nans;
    logic [6:0]  group_setting;
    logic [63:0] running_min [MAX_GROUPS];
    logic        saw_number  [MAX_GROUPS];
    logic        saw_nan     [MAX_GROUPS];
    logic [63:0] column_first_nan;
    int          fail_total;
    int          pending_count;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_count;

    function automatic logic bits_are_nan(input logic [63:0] b);
        return (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
    endfunction

    function automatic int groups_in_use();
        if (group_setting == 7'd0) return 1;
        if (group_setting > MAX_GROUPS) return MAX_GROUPS;
        return int'(group_setting);
    endfunction

    task automatic clear_table();
        for (int k = 0; k < MAX_GROUPS; k++) begin
            running_min[k] = drop_nans ? gmr_pkg::NA_BITS : gmr_pkg::INF_BITS;
            saw_number[k]  = 1'b0;
            saw_nan[k]     = 1'b0;
        end
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch: %s got %h expected %h", what, got, want);
        fail_total++;
    endtask

    // Folds one sample into its group, following the NaN policy in force.
    task automatic fold_sample(input int idx, input logic [63:0] x);
        logic nan;
        nan = bits_are_nan(x);
        if (drop_nans) begin
            if (nan) begin
                if (!saw_nan[idx]) begin
                    saw_nan[idx] = 1'b1;
                    if (group_setting == 7'd0) column_first_nan = x;
                end
            end else if (!saw_number[idx] ||
                         $bitstoreal(running_min[idx]) > $bitstoreal(x)) begin
                running_min[idx] = x;
                saw_number[idx]  = 1'b1;
            end
        end else if (!saw_nan[idx]) begin
            if (nan) begin
                running_min[idx] = x;
                saw_nan[idx]     = 1'b1;
            end else begin
                saw_number[idx] = 1'b1;
                if ($bitstoreal(running_min[idx]) > $bitstoreal(x)) running_min[idx] = x;
            end
        end
    endtask

    task automatic absorb_item(input logic [63:0] x, input logic [6:0] g, input logic eoc);
        int n;
        t_group_result r;
        n = groups_in_use();
        if (group_setting == 7'd0) begin
            fold_sample(0, x);
        end else if (g >= 7'd1 && int'(g) <= n) begin
            fold_sample(int'(g) - 1, x);
        end
        if (eoc) begin
            for (int k = 0; k < n; k++) begin
                r.grp      = 7'(k + 1);
                r.min_bits = running_min[k];
                if (drop_nans && group_setting == 7'd0 && !saw_number[0])
                    r.min_bits = column_first_nan;
                r.last = (k + 1 == n);
                expected_minima.push_back(r);
            end
            clear_table();
        end
    endtask

    initial begin
        fail_total    = 0;
        pending_count = 0;
    end

    always @(posedge i_clk) begin
        t_group_result want;
        if (!i_rst_n) begin
            drop_nans        = 1'b1;
            group_setting    = 7'd0;
            column_first_nan = 64'd0;
            clear_table();
            expected_minima.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_minima.size() == 0) begin
                    report("result with nothing expected", i_m_tdata[63:0], 64'd0);
                end else begin
                    want = expected_minima.pop_front();
                    if (i_m_tdata[6:0] != want.grp)
                        report("result_group", 64'(i_m_tdata[6:0]), 64'(want.grp));
                    if (i_m_tdata[70:7] != want.min_bits)
                        report("minimum_bits", i_m_tdata[70:7], want.min_bits);
                    if (i_m_tlast != want.last)
                        report("last_result", 64'(i_m_tlast), 64'(want.last));
                end
            end
            if (i_s_tvalid && i_s_tready)
                absorb_item(i_s_tdata[63:0], i_s_tdata[70:64], i_s_tlast);
            if (i_cfg_we) begin
                if (i_cfg_idx == gmr_pkg::REG_NA_REMOVE) drop_nans = i_cfg_wdata[0];
                else group_setting = i_cfg_wdata;
                clear_table();
            end
        end
        pending_count = expected_minima.size();
    end

endmodule

@@ tb/testbench.sv @@
// Top of the grouped_min_reduce testbench: clock, reset, stimulus, receiver
// stalls and the verdict. Depends on gmr_pkg, the block and gmr_checker.
module testbench;

    localparam int RUN_LIMIT = 600000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    gmr_pkg::t_reg_idx i_cfg_idx;
    logic [6:0]  i_cfg_wdata;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [71:0] i_s_tdata;   // [63:0] sample_bits, [70:64] group_number, [71] zero
    logic        i_s_tlast;   // end_of_column
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [71:0] o_m_tdata;   // [6:0] result_group, [70:7] minimum_bits, [71] zero
    logic        o_m_tlast;   // last_result

    int   fail_count;
    int   pending;
    int   cycle_count;
    logic item_taken;
    logic long_hold_req;

    grouped_min_reduce uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tlast(i_s_tlast),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tlast(o_m_tlast)
    );

    gmr_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid(i_s_tvalid), .i_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tlast(i_s_tlast),
        .i_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .i_m_tdata(o_m_tdata), .i_m_tlast(o_m_tlast),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // The handshake is captured with a nonblocking assignment, so the value
    // seen at the next falling edge is what the block saw at the rising edge.
    always @(posedge i_clk) begin
        item_taken <= i_s_tvalid && o_s_tready;
    end

    // A hung block ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // The receiver switches at random between stall patterns of its own.
    // Once, on request from the sender, it holds off for a long stretch
    // so that a full dump backs up into the sample input.
    initial begin : receiver
        int mode;
        int mode_left;
        int hold_left;
        logic hold_used;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        hold_used = 1'b0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req && !hold_used) begin
                hold_used = 1'b1;
                hold_left = 400;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 64);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                case (mode)
                    0: i_m_tready <= 1'b1;
                    1: i_m_tready <= ($urandom_range(0, 3) != 0);
                    2: i_m_tready <= ($urandom_range(0, 4) == 0);
                    default: i_m_tready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the item
    // was accepted, with valid still high.
    task automatic send_sample(input logic [63:0] x, input logic [6:0] g, input logic eoc);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, g, x};
        i_s_tlast  <= eoc;
        do @(negedge i_clk); while (!item_taken);
    endtask

    // Drops valid and waits until every expected result has arrived and the block
    // is idle.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input gmr_pkg::t_reg_idx idx, input logic [6:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    // Sample values weighted toward the cases that decide a minimum: zeros of
    // both signs, infinities, NaNs and NA, subnormals and a small pool of
    // values that produce ties.
    function automatic logic [63:0] pick_sample();
        logic [63:0] r;
        logic [51:0] mant;
        logic        sgn;
        r    = {$urandom, $urandom};
        sgn  = 1'($urandom_range(0, 1));
        mant = r[51:0] | (52'd1 << $urandom_range(0, 51));
        case ($urandom_range(0, 11))
            0, 1:    return r;
            2:       return {sgn, 63'd0};
            3:       return {sgn, 11'h7FF, 52'd0};
            4:       return {sgn, 11'h7FF, mant};
            5:       return gmr_pkg::NA_BITS;
            6, 7, 8: return $realtobits(real'($urandom_range(0, 6)) - 3.0);
            9:       return {sgn, 11'h000, r[51:0]};
            10:      return {sgn, 11'h7FE, 52'hF_FFFF_FFFF_FFFF};
            default: return {sgn, 11'($urandom_range(1, 2046)), r[51:0]};
        endcase
    endfunction

    function automatic logic [6:0] pick_group(input int used);
        case ($urandom_range(0, 15))
            0:       return 7'($urandom_range(0, 127));
            1:       return 7'd0;
            2:       return 7'(used + 1);
            default: return 7'($urandom_range(1, (used < 1) ? 1 : used));
        endcase
    endfunction

    initial begin : stimulus
        int burst_left;
        int used;
        int phase_items;
        logic [6:0] counts [8];
        cycle_count   = 0;
        long_hold_req = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = gmr_pkg::REG_NA_REMOVE;
        i_cfg_wdata = 7'd0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = 72'd0;
        i_s_tlast   = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: NaNs dropped, one whole-column group. A tie between
        // -0 and +0 keeps the earlier one.
        send_sample($realtobits(5.0), 7'd9, 1'b0);
        send_sample({1'b1, 63'd0}, 7'd0, 1'b0);
        send_sample(64'd0, 7'd3, 1'b0);
        send_sample({1'b0, 11'h7FF, 52'd5}, 7'd1, 1'b1);
        // A column of NaNs only reports its first NaN.
        send_sample({1'b1, 11'h7FF, 52'hF_FFFF_FFFF_FFFF}, 7'd1, 1'b0);
        send_sample({1'b0, 11'h7FF, 52'd1}, 7'd1, 1'b1);

        // NaN kept: the first NaN sticks, and an empty group gives +Inf.
        write_reg(gmr_pkg::REG_NA_REMOVE, 7'd0);
        write_reg(gmr_pkg::REG_GROUP_COUNT, 7'd3);
        send_sample($realtobits(2.0), 7'd1, 1'b0);
        send_sample({1'b0, 11'h7FF, 52'd7}, 7'd1, 1'b0);
        send_sample($realtobits(-9.0), 7'd1, 1'b0);
        send_sample(64'd0, 7'd2, 1'b0);
        send_sample({1'b1, 63'd0}, 7'd2, 1'b0);
        send_sample($realtobits(-1.0), 7'd0, 1'b0);
        send_sample($realtobits(-1.0), 7'd4, 1'b1);
        // NaN dropped with groups: an empty group gives NA.
        write_reg(gmr_pkg::REG_NA_REMOVE, 7'd1);
        send_sample({1'b1, 11'h7FF, 52'd0}, 7'd1, 1'b0);
        send_sample({1'b0, 11'h7FF, 52'd9}, 7'd2, 1'b0);
        send_sample(64'hFFFF_FFFF_FFFF_FFFF, 7'd3, 1'b0);
        send_sample(64'd1, 7'd3, 1'b1);
        // An oversized group count acts as the full table.
        write_reg(gmr_pkg::REG_GROUP_COUNT, 7'd127);
        send_sample({1'b1, 11'h7FE, 52'hF_FFFF_FFFF_FFFF}, 7'd64, 1'b0);
        send_sample($realtobits(3.0), 7'd127, 1'b1);

        // Random phases through a spread of settings, extremes included.
        counts[0] = 7'd0;  counts[1] = 7'd1;  counts[2] = 7'd64; counts[3] = 7'd2;
        counts[4] = 7'd100; counts[5] = 7'd64; counts[6] = 7'd5; counts[7] = 7'd0;
        burst_left = 0;
        for (int p = 0; p < 8; p++) begin
            write_reg(gmr_pkg::REG_NA_REMOVE, 7'($urandom_range(0, 127)));
            write_reg(gmr_pkg::REG_GROUP_COUNT, counts[p]);
            used = (counts[p] == 0) ? 1 : ((counts[p] > 64) ? 64 : int'(counts[p]));
            phase_items = (used > 8) ? 60 : 30;
            for (int i = 0; i < phase_items; i++) begin
                // In the last full-table phase the receiver holds off while
                // samples keep coming.
                if (p == 5 && i == 5) long_hold_req <= 1'b1;
                if (p == 3 && i == 15) drain();
                if (burst_left == 0) begin
                    if ($urandom_range(0, 2) != 0) begin
                        i_s_tvalid <= 1'b0;
                        repeat ($urandom_range(1, 12)) @(negedge i_clk);
                    end
                    burst_left = $urandom_range(1, 20);
                end
                burst_left--;
                send_sample(pick_sample(), pick_group(used),
                            (used > 8) ? ($urandom_range(0, 19) == 0)
                                       : ($urandom_range(0, 5) == 0));
            end
            send_sample(pick_sample(), pick_group(used), 1'b1);
        end

        drain();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/gmr_pkg.sv
hw/rtl/gmr_cell.sv
hw/rtl/grouped_min_reduce.sv
tb/gmr_checker.sv
tb/testbench.sv
